[rtl/core/abpdu_pkg.sv]
// Package for the box projection and dual update block.
// Shared types, codes and constants; no dependencies.
`default_nettype none

package abpdu_pkg;

  localparam int unsigned ResBits  = 31;
  localparam int unsigned CntBits  = 16;
  localparam int unsigned DataBits = 32;
  localparam int unsigned AddrBits = 5;
  localparam int unsigned CfgIdxBits = 3;

  localparam logic [ResBits-1:0] ResMax = '1;

  typedef enum logic [1:0] {
    STAT_RUN,
    STAT_SOLVED,
    STAT_NONCONVEX,
    STAT_MAXITER
  } solve_status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ENABLE,
    CFG_RHO,
    CFG_PRI_TOL,
    CFG_DUA_TOL,
    CFG_DIV_LIM,
    CFG_ITER_LIM,
    CFG_CHECK_EVERY
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_PROJ,
    ST_DUAL,
    ST_MUL,
    ST_CHECK,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic               enable;
    logic [ResBits-1:0] rho;
    logic [ResBits-1:0] pri_tol;
    logic [ResBits-1:0] dua_tol;
    logic [ResBits-1:0] div_lim;
    logic [CntBits-1:0] iter_lim;
    logic [CntBits-1:0] check_every;
  } cfg_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic add;
    logic proj;
    logic dual;
    logic mul;
    logic check;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sweep_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/abpdu_if.sv]
// Valid/ready item channels of the box projection and dual update block.
// Stand-alone; no package needed.
`default_nettype none

interface abpdu_in_if;
  logic               valid;
  logic               ready;
  logic               start_solve;
  logic [3:0]         horizon_step;
  logic [1:0]         component;
  logic signed [31:0] control_value;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic               sweep_end;

  modport source (
    output valid, start_solve, horizon_step, component, control_value,
           lower_bound, upper_bound, sweep_end,
    input  ready
  );
  modport sink (
    input  valid, start_solve, horizon_step, component, control_value,
           lower_bound, upper_bound, sweep_end,
    output ready
  );
endinterface

interface abpdu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] slack_value;
  logic signed [31:0] dual_value;
  logic               sweep_done;
  logic [1:0]         solve_status;
  logic [15:0]        iteration_number;
  logic [30:0]        primal_residual;
  logic [30:0]        dual_residual;

  modport source (
    output valid, slack_value, dual_value, sweep_done, solve_status,
           iteration_number, primal_residual, dual_residual,
    input  ready
  );
  modport sink (
    input  valid, slack_value, dual_value, sweep_done, solve_status,
           iteration_number, primal_residual, dual_residual,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/abpdu_ctrl.sv]
// Sequencer of the box projection and dual update block.
// Steps one item through the datapath; uses abpdu_pkg.
`default_nettype none

module abpdu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  abpdu_pkg::sts_t   sts_i,
  output abpdu_pkg::cmd_t   cmd_o
);
  import abpdu_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_ADD;
      ST_ADD:   state_d = ST_PROJ;
      ST_PROJ:  state_d = ST_DUAL;
      ST_DUAL:  state_d = sts_i.sweep_end ? ST_MUL : ST_DONE;
      ST_MUL:   state_d = ST_CHECK;
      ST_CHECK: state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_ADD:   cmd_o.add = 1'b1;
      ST_PROJ:  cmd_o.proj = 1'b1;
      ST_DUAL:  cmd_o.dual = 1'b1;
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_CHECK: cmd_o.check = 1'b1;
      ST_DONE:  cmd_o.load_out = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  a_accept_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_ADD)
    else $error("item accepted but sequencer did not start");
  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == ST_IDLE)
    else $error("result loaded but sequencer not idle");
  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sts_i.clr_last) |=> state_q == ST_IDLE)
    else $error("clearing pass did not end");

endmodule

`default_nettype wire

[rtl/core/abpdu_dp.sv]
// Datapath: dual/slack memory, projection, residual tracking, status.
// Driven by abpdu_ctrl; uses abpdu_pkg and the channel interfaces.
`default_nettype none

module abpdu_dp #(
  parameter int unsigned HORIZON_STEPS    = 16,
  parameter int unsigned INPUT_COMPONENTS = 4,
  parameter int unsigned VALUE_BITS       = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  abpdu_pkg::cfg_t  cfg_i,
  input  abpdu_pkg::cmd_t  cmd_i,
  output abpdu_pkg::sts_t  sts_o,
  input  logic             in_ready_i,
  abpdu_in_if.sink         in_i,
  abpdu_out_if.source      out_o
);
  import abpdu_pkg::*;

  localparam int unsigned Depth = HORIZON_STEPS * INPUT_COMPONENTS;
  localparam int unsigned MemAw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw    = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 2;
  localparam int unsigned Vb    = VALUE_BITS;

  function automatic logic signed [Cw-1:0] sat_w(input logic signed [Cw-1:0] v,
                                                 input int unsigned bits);
    logic signed [Cw-1:0] hi;
    logic signed [Cw-1:0] lo;
    hi = signed'((Cw'(1) << (bits - 1)) - Cw'(1));
    lo = -hi - Cw'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [ResBits-1:0] abs_sat(input logic signed [Cw-1:0] a,
                                                 input logic signed [Cw-1:0] b);
    logic signed [Cw-1:0] d;
    d = a - b;
    if (d < 0) d = -d;
    if (d > signed'(Cw'(ResMax))) return ResMax;
    return d[ResBits-1:0];
  endfunction

  // item capture
  logic [13:0]        addr_full;
  logic               in_range;
  logic [MemAw-1:0]   in_addr;
  logic [MemAw-1:0]   addr_q;
  logic               inr_q;
  logic               se_q;
  logic signed [31:0] u_q;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;

  assign addr_full = 14'(in_i.horizon_step) * 14'(INPUT_COMPONENTS) + 14'(in_i.component);
  assign in_range  = (9'(in_i.horizon_step) < 9'(HORIZON_STEPS)) &&
                     (5'(in_i.component) < 5'(INPUT_COMPONENTS));
  assign in_addr   = addr_full[MemAw-1:0];
  assign in_i.ready = in_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= in_addr;
      inr_q  <= in_range;
      se_q   <= in_i.sweep_end;
      u_q    <= in_i.control_value;
      lo_q   <= in_i.lower_bound;
      hi_q   <= in_i.upper_bound;
    end
  end

  // memory: dual in the upper half, slack in the lower half
  logic [2*Vb-1:0]  mem_q [Depth];
  logic [2*Vb-1:0]  rd_q;
  logic [MemAw-1:0] clr_q;
  logic             we;
  logic [MemAw-1:0] wa;
  logic [2*Vb-1:0]  wd;
  logic signed [Cw-1:0] y2;
  logic signed [Cw-1:0] z_q;

  assign we = cmd_i.clr_wr || (cmd_i.dual && cfg_i.enable && inr_q);
  assign wa = cmd_i.clr_wr ? clr_q : addr_q;
  assign wd = cmd_i.clr_wr ? '0 : {y2[Vb-1:0], z_q[Vb-1:0]};

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (cmd_i.accept) rd_q <= mem_q[in_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + MemAw'(1);
    end
  end

  assign sts_o.clr_last  = (clr_q == MemAw'(Depth - 1));
  assign sts_o.sweep_end = se_q;

  // arithmetic
  logic signed [Cw-1:0] u_x;
  logic signed [Cw-1:0] lo_x;
  logic signed [Cw-1:0] hi_x;
  logic signed [Cw-1:0] y_old;
  logic signed [Cw-1:0] z_old;
  logic signed [Cw-1:0] y1_q;
  logic signed [Cw-1:0] zc;
  logic [ResBits-1:0]   dpri;
  logic [ResBits-1:0]   dchg;

  assign u_x   = Cw'(u_q);
  assign lo_x  = Cw'(lo_q);
  assign hi_x  = Cw'(hi_q);
  assign y_old = Cw'(signed'(rd_q[2*Vb-1:Vb]));
  assign z_old = Cw'(signed'(rd_q[Vb-1:0]));

  always_comb begin
    zc = y1_q;
    if (zc > hi_x) zc = hi_x;
    if (zc < lo_x) zc = lo_x;
  end

  assign y2   = sat_w(y1_q - z_q, Vb);
  assign dpri = abs_sat(u_x, z_q);
  assign dchg = abs_sat(z_q, z_old);

  always_ff @(posedge clk_i) begin
    if (cmd_i.add)  y1_q <= sat_w(y_old + u_x, Vb);
    if (cmd_i.proj) z_q  <= sat_w(zc, Vb);
  end

  logic signed [31:0] zout_q;
  logic signed [31:0] yout_q;
  logic signed [Cw-1:0] zo_full;
  logic signed [Cw-1:0] yo_full;

  always_comb begin
    zo_full = '0;
    yo_full = '0;
    if (inr_q) begin
      if (cfg_i.enable) begin
        zo_full = sat_w(z_q, 32);
        yo_full = sat_w(y2, 32);
      end else begin
        zo_full = sat_w(z_old, 32);
        yo_full = sat_w(y_old, 32);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dual) begin
      zout_q <= zo_full[31:0];
      yout_q <= yo_full[31:0];
    end
  end

  // residual tracking and termination
  logic [ResBits-1:0]   pmax_q;
  logic [ResBits-1:0]   scm_q;
  logic [2*ResBits-1:0] prod_q;
  logic [2*ResBits-17:0] prod_sh;
  logic [ResBits-1:0]   dua;
  logic [ResBits-1:0]   res_pri_q;
  logic [ResBits-1:0]   res_dua_q;
  solve_status_e        status_q, status_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [CntBits-1:0]   cd_q, cd_d;
  logic [CntBits:0]     cd_inc;
  logic                 start;

  assign start   = cmd_i.accept && in_i.start_solve;
  assign prod_sh = prod_q[2*ResBits-1:16];
  assign dua     = (|prod_sh[2*ResBits-17:ResBits]) ? ResMax : prod_sh[ResBits-1:0];
  assign cd_inc  = {1'b0, cd_q} + (CntBits+1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= (2*ResBits)'(cfg_i.rho) * (2*ResBits)'(scm_q);
    if (cmd_i.check) begin
      res_pri_q <= pmax_q;
      res_dua_q <= dua;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmax_q <= '0;
      scm_q  <= '0;
    end else if (start || cmd_i.check) begin
      pmax_q <= '0;
      scm_q  <= '0;
    end else if (cmd_i.dual && cfg_i.enable && inr_q) begin
      if (dpri > pmax_q) pmax_q <= dpri;
      if (dchg > scm_q)  scm_q  <= dchg;
    end
  end

  always_comb begin
    status_d = status_q;
    cnt_d    = cnt_q;
    cd_d     = cd_q;
    if (start) begin
      status_d = STAT_RUN;
      cnt_d    = '0;
      cd_d     = '0;
    end else if (cmd_i.check && status_q == STAT_RUN) begin
      cnt_d = (cnt_q != '1) ? cnt_q + CntBits'(1) : cnt_q;
      if (cfg_i.check_every != '0) begin
        cd_d = cd_inc[CntBits-1:0];
        if (cd_inc >= {1'b0, cfg_i.check_every}) begin
          cd_d = '0;
          if (pmax_q > cfg_i.div_lim || dua > cfg_i.div_lim) begin
            status_d = STAT_NONCONVEX;
          end else if (pmax_q < cfg_i.pri_tol && dua < cfg_i.dua_tol) begin
            status_d = STAT_SOLVED;
          end
        end
      end
      if (status_d == STAT_RUN && cnt_d >= cfg_i.iter_lim) status_d = STAT_MAXITER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= STAT_RUN;
      cnt_q    <= '0;
      cd_q     <= '0;
    end else begin
      status_q <= status_d;
      cnt_q    <= cnt_d;
      cd_q     <= cd_d;
    end
  end

  // output register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_o.slack_value      <= zout_q;
      out_o.dual_value       <= yout_q;
      out_o.sweep_done       <= se_q;
      out_o.solve_status     <= se_q ? status_q : STAT_RUN;
      out_o.iteration_number <= se_q ? cnt_q : '0;
      out_o.primal_residual  <= se_q ? res_pri_q : '0;
      out_o.dual_residual    <= se_q ? res_dua_q : '0;
    end
  end

  assign out_o.valid = out_valid_q;

  a_status_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != STAT_RUN && !cmd_i.accept) |=> ($stable(status_q) && $stable(cnt_q)))
    else $error("terminated status changed without a new solve");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_o.ready))
    else $error("undelivered result overwritten");
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check |=> (pmax_q == '0 && scm_q == '0))
    else $error("residual trackers not cleared after sweep");

endmodule

`default_nettype wire

[rtl/core/admm_box_projection_dual_update.sv]
// ADMM slack projection and scaled dual update over box bounds, Q16.16.
// Each item is a read-modify-write of the dual/slack memory, stepped by the sequencer through
// the add, projection and dual steps, plus the rho multiply and check when it closes a sweep.
// A new item is taken only after the last result has been loaded into the output register.
// Reset: registers with a reset return to defaults at once; the memory is then cleared
// entry by entry with the input not ready. Uses abpdu_pkg.
`default_nettype none

module admm_box_projection_dual_update #(
  parameter int unsigned HORIZON_STEPS    = 16,
  parameter int unsigned INPUT_COMPONENTS = 4,
  parameter int unsigned VALUE_BITS       = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  abpdu_in_if.sink                         in_i,
  abpdu_out_if.source                      out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [abpdu_pkg::AddrBits-1:0]   paddr,
  input  logic [abpdu_pkg::DataBits-1:0]   pwdata,
  output logic [abpdu_pkg::DataBits-1:0]   prdata,
  output logic                             pready
);
  import abpdu_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  sts_t     sts;
  logic     in_ready;
  logic     cfg_we;
  cfg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_e'(paddr[AddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable      <= 1'b1;
      cfg_q.rho         <= ResBits'(65536);
      cfg_q.pri_tol     <= ResBits'(66);
      cfg_q.dua_tol     <= ResBits'(66);
      cfg_q.div_lim     <= ResMax;
      cfg_q.iter_lim    <= CntBits'(100);
      cfg_q.check_every <= CntBits'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ENABLE:      cfg_q.enable      <= pwdata[0];
        CFG_RHO:         cfg_q.rho         <= pwdata[ResBits-1:0];
        CFG_PRI_TOL:     cfg_q.pri_tol     <= pwdata[ResBits-1:0];
        CFG_DUA_TOL:     cfg_q.dua_tol     <= pwdata[ResBits-1:0];
        CFG_DIV_LIM:     cfg_q.div_lim     <= pwdata[ResBits-1:0];
        CFG_ITER_LIM:    cfg_q.iter_lim    <= pwdata[CntBits-1:0];
        CFG_CHECK_EVERY: cfg_q.check_every <= pwdata[CntBits-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_ENABLE:      prdata = DataBits'(cfg_q.enable);
      CFG_RHO:         prdata = DataBits'(cfg_q.rho);
      CFG_PRI_TOL:     prdata = DataBits'(cfg_q.pri_tol);
      CFG_DUA_TOL:     prdata = DataBits'(cfg_q.dua_tol);
      CFG_DIV_LIM:     prdata = DataBits'(cfg_q.div_lim);
      CFG_ITER_LIM:    prdata = DataBits'(cfg_q.iter_lim);
      CFG_CHECK_EVERY: prdata = DataBits'(cfg_q.check_every);
      default:         prdata = '0;
    endcase
  end

  abpdu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abpdu_dp #(
    .HORIZON_STEPS    (HORIZON_STEPS),
    .INPUT_COMPONENTS (INPUT_COMPONENTS),
    .VALUE_BITS       (VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_ready_i (in_ready),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
